FILE: rtl/core/stbs_pkg.sv
// ----------------------------------------------------------------------------
// stbs_pkg
// Shared types and constants for the sorted table binary search core.
// ----------------------------------------------------------------------------
package stbs_pkg;

    localparam int DEPTH_DEF  = 1024;
    localparam int IDX_W      = 10;
    localparam int DATA_W     = 32;
    localparam int S_TDATA_W  = 80;
    localparam int M_TDATA_W  = 16;

    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_SEARCH = 1'b1
    } t_opcode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DECIDE,
        ST_CHECK,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic start;
        logic take;
    } t_seq_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_seq_stat;

endpackage

FILE: rtl/core/stbs_table.sv
// ----------------------------------------------------------------------------
// stbs_table
// Table memory: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module stbs_table #(
    parameter int DEPTH = stbs_pkg::DEPTH_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic                              i_clk,
    input  logic                              i_we,
    input  logic [AW-1:0]                     i_waddr,
    input  logic signed [stbs_pkg::DATA_W-1:0] i_wdata,
    input  logic [AW-1:0]                     i_raddr_a,
    input  logic [AW-1:0]                     i_raddr_b,
    output logic signed [stbs_pkg::DATA_W-1:0] o_rdata_a,
    output logic signed [stbs_pkg::DATA_W-1:0] o_rdata_b
);

    logic signed [stbs_pkg::DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

FILE: rtl/core/stbs_seq.sv
// ----------------------------------------------------------------------------
// stbs_seq
// Search sequencer: range registers, one shared adder and the compare step.
// ----------------------------------------------------------------------------
module stbs_seq #(
    parameter int DEPTH = stbs_pkg::DEPTH_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  stbs_pkg::t_seq_ctl                 i_ctl,
    input  logic signed [stbs_pkg::DATA_W-1:0] i_key,
    input  logic signed [stbs_pkg::DATA_W-1:0] i_rdata_a,
    input  logic signed [stbs_pkg::DATA_W-1:0] i_rdata_b,
    output logic [AW-1:0]                      o_raddr_a,
    output logic [AW-1:0]                      o_raddr_b,
    output stbs_pkg::t_seq_stat                o_stat,
    output logic [AW-1:0]                      o_result
);

    localparam logic [AW-1:0] TWO  = AW'(2);
    localparam logic [AW-1:0] ONE  = AW'(1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    stbs_pkg::t_state r_state, n_state;
    logic [AW-1:0] r_low, n_low;
    logic [AW-1:0] r_high, n_high;
    logic [AW-1:0] r_result, n_result;
    logic signed [stbs_pkg::DATA_W-1:0] r_key, n_key;

    logic [AW-1:0] diff;
    logic          step_big;
    logic [AW-1:0] addend;
    logic [AW-1:0] sum;

    // shared adder: mid during narrowing, low+1 for the final check
    assign diff     = r_high - r_low;
    assign step_big = diff > TWO;
    assign addend   = step_big ? (diff >> 1) : ONE;
    assign sum      = r_low + addend;

    assign o_raddr_a = step_big ? r_low : sum;
    assign o_raddr_b = sum;
    assign o_result  = r_result;
    assign o_stat.busy = (r_state != stbs_pkg::ST_IDLE);
    assign o_stat.done = (r_state == stbs_pkg::ST_DONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stbs_pkg::ST_IDLE;
            r_low   <= '0;
            r_high  <= LAST;
        end else begin
            r_state <= n_state;
            r_low   <= n_low;
            r_high  <= n_high;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key    <= n_key;
        r_result <= n_result;
    end

    always_comb begin
        n_state  = r_state;
        n_low    = r_low;
        n_high   = r_high;
        n_key    = r_key;
        n_result = r_result;
        unique case (r_state)
            stbs_pkg::ST_IDLE: begin
                if (i_ctl.start) begin
                    n_low   = '0;
                    n_high  = LAST;
                    n_key   = i_key;
                    n_state = stbs_pkg::ST_ISSUE;
                end
            end
            stbs_pkg::ST_ISSUE: begin
                if (step_big) begin
                    n_state = stbs_pkg::ST_DECIDE;
                end else if (diff == TWO) begin
                    n_state = stbs_pkg::ST_CHECK;
                end else begin
                    n_result = r_low;
                    n_state  = stbs_pkg::ST_DONE;
                end
            end
            stbs_pkg::ST_DECIDE: begin
                if (i_rdata_a <= r_key && i_rdata_b >= r_key) begin
                    n_high = sum;
                end else begin
                    n_low  = sum;
                end
                n_state = stbs_pkg::ST_ISSUE;
            end
            stbs_pkg::ST_CHECK: begin
                n_result = (i_rdata_a == r_key) ? sum : r_low;
                n_state  = stbs_pkg::ST_DONE;
            end
            stbs_pkg::ST_DONE: begin
                if (i_ctl.take) begin
                    n_state = stbs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = stbs_pkg::ST_IDLE;
            end
        endcase
    end

    a_range_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_low < r_high)
        else $error("search range collapsed");

    a_high_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_high <= LAST)
        else $error("range end beyond table");

    a_range_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == stbs_pkg::ST_DECIDE |=> (r_high - r_low) < $past(r_high - r_low))
        else $error("narrowing step did not shrink range");

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.start |-> r_state == stbs_pkg::ST_IDLE)
        else $error("search started while busy");

    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == stbs_pkg::ST_DONE && i_ctl.take) |=> r_state == stbs_pkg::ST_IDLE)
        else $error("result handed over but sequencer not idle");

endmodule

FILE: rtl/core/sorted_table_binary_search_core.sv
// ----------------------------------------------------------------------------
// sorted_table_binary_search_core
// Table of signed words with a narrowing search over it.
// ----------------------------------------------------------------------------
// Input stream: s_axis_tuser is the opcode (0 write, 1 search). A write item
// stores entry_value at entry_index and gives no result; an index
// at or beyond DEPTH is dropped. A search item gives one output item carrying
// the index reached by the narrowing search.
// Search steps: each narrowing step issues both reads on the two table ports,
// then compares and moves one end of the range; about ceil(log2(DEPTH)) - 1
// steps run, nine for DEPTH = 1024. A last read for the two-wide check may
// follow, then the result is handed over, and the next search can be taken
// only after that hand-over. The step loop through the table read ports sets
// the search time. s_axis_tready is low while a search runs; a write does
// not lower it.
// The result sits in an output register; the core takes a new item while it
// waits. If the receiver stalls with a result still held, a finished search
// waits in its last state until the register frees.
// Reset clears the control state only; table contents are undefined until
// written.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_core #(
    parameter int DEPTH = stbs_pkg::DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // entry_index [9:0], entry_value [41:10], search_key [73:42], zero pad
    input  logic [stbs_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // opcode [0]
    input  logic                             s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // result_index [9:0], zero pad
    output logic [stbs_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = (AW > stbs_pkg::IDX_W ? AW : stbs_pkg::IDX_W) + 1;

    stbs_pkg::t_opcode   opcode;
    stbs_pkg::t_seq_ctl  ctl;
    stbs_pkg::t_seq_stat stat;

    logic                               accept;
    logic [stbs_pkg::IDX_W-1:0]         entry_index;
    logic signed [stbs_pkg::DATA_W-1:0] entry_value;
    logic signed [stbs_pkg::DATA_W-1:0] search_key;
    logic [CW-1:0]                      idx_ext;
    logic                               we;
    logic [AW-1:0]                      raddr_a, raddr_b;
    logic signed [stbs_pkg::DATA_W-1:0] rdata_a, rdata_b;
    logic [AW-1:0]                      result;
    logic [CW-1:0]                      result_ext;
    logic                               out_free;

    logic                               r_m_valid, n_m_valid;
    logic [stbs_pkg::M_TDATA_W-1:0]     r_m_data, n_m_data;

    assign opcode      = stbs_pkg::t_opcode'(s_axis_tuser);
    assign entry_index = s_axis_tdata[stbs_pkg::IDX_W-1:0];
    assign entry_value = s_axis_tdata[stbs_pkg::IDX_W +: stbs_pkg::DATA_W];
    assign search_key  = s_axis_tdata[stbs_pkg::IDX_W + stbs_pkg::DATA_W +: stbs_pkg::DATA_W];

    assign s_axis_tready = !stat.busy;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign idx_ext       = CW'(entry_index);
    assign we            = accept && (opcode == stbs_pkg::OP_WRITE)
                           && (idx_ext < CW'(DEPTH));

    assign out_free  = !r_m_valid || m_axis_tready;
    assign ctl.start = accept && (opcode == stbs_pkg::OP_SEARCH);
    assign ctl.take  = stat.done && out_free;

    assign result_ext = CW'(result);

    stbs_table #(
        .DEPTH(DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (idx_ext[AW-1:0]),
        .i_wdata   (entry_value),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    stbs_seq #(
        .DEPTH(DEPTH)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (ctl),
        .i_key     (search_key),
        .i_rdata_a (rdata_a),
        .i_rdata_b (rdata_b),
        .o_raddr_a (raddr_a),
        .o_raddr_b (raddr_b),
        .o_stat    (stat),
        .o_result  (result)
    );

    always_comb begin
        n_m_valid = r_m_valid;
        n_m_data  = r_m_data;
        if (ctl.take) begin
            n_m_valid = 1'b1;
            n_m_data  = stbs_pkg::M_TDATA_W'(result_ext[stbs_pkg::IDX_W-1:0]);
        end else if (m_axis_tready) begin
            n_m_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else begin
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_data <= n_m_data;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule
